// ----- hdl/pbrd_pkg.sv -----
`default_nettype none

package pbrd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned LIMIT_W = 15;
   localparam int unsigned SRC_W   = 16;

   // tdata widths, padded to whole bytes
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      PH_CONTROL,
      PH_LITERAL,
      PH_REPEAT,
      PH_DONE
   } phase_type;

   typedef struct packed {
      phase_type            phase;
      logic [BYTE_W-1:0]    lit_left;
      logic [BYTE_W-1:0]    pend_repeat;
      logic [LIMIT_W-1:0]   out_count;
      logic [SRC_W-1:0]     src_count;
   } state_type;

   typedef struct packed {
      logic [SRC_W-1:0]     bytes_consumed;
      logic [BYTE_W-1:0]    repeat_count;
      logic [BYTE_W-1:0]    out_byte;
      logic                 done_res;
   } result_type;

   localparam state_type STATE_CLEAR = '{
      phase:       PH_CONTROL,
      lit_left:    '0,
      pend_repeat: '0,
      out_count:   '0,
      src_count:   '0
   };

endpackage

`default_nettype wire

// ----- hdl/pbrd_step.sv -----
`default_nettype none

module pbrd_step
   import pbrd_pkg::*;
(
   input  state_type          state_cur,
   input  logic [BYTE_W-1:0]  src_byte,
   input  logic               restart,
   input  logic [LIMIT_W-1:0] output_limit,
   output state_type          state_nxt,
   output logic               res_hit,
   output result_type         res
);

   state_type           cur;
   logic [LIMIT_W-1:0]  room;
   logic [BYTE_W-1:0]   cnt;
   logic                is_data;
   logic [LIMIT_W:0]    sum;
   logic [LIMIT_W-1:0]  new_count;
   logic [BYTE_W-1:0]   left_dec;

   always_comb begin
      cur       = restart ? STATE_CLEAR : state_cur;
      state_nxt = cur;
      res_hit   = 1'b0;
      res       = '0;
      cnt       = '0;
      is_data   = 1'b0;
      room      = output_limit - cur.out_count;
      left_dec  = (cur.lit_left != '0) ? cur.lit_left - 8'd1 : '0;
      sum       = '0;
      new_count = cur.out_count;

      if (cur.phase == PH_DONE || cur.out_count >= output_limit) begin
         state_nxt.phase    = PH_DONE;
         res_hit            = 1'b1;
         res.done_res       = 1'b1;
         res.bytes_consumed = cur.src_count;
      end else begin
         if (cur.src_count != '1) begin
            state_nxt.src_count = cur.src_count + 16'd1;
         end
         unique case (cur.phase)
            PH_CONTROL: begin
               if (!src_byte[7]) begin
                  state_nxt.lit_left = {1'b0, src_byte[6:0]} + 8'd1;
                  state_nxt.phase    = PH_LITERAL;
               end else begin
                  state_nxt.pend_repeat = BYTE_W'(9'd257 - {1'b0, src_byte});
                  state_nxt.phase       = PH_REPEAT;
               end
            end
            PH_LITERAL: begin
               is_data            = 1'b1;
               cnt                = 8'd1;
               state_nxt.lit_left = left_dec;
               if (left_dec == '0) begin
                  state_nxt.phase = PH_CONTROL;
               end
            end
            PH_REPEAT: begin
               is_data = 1'b1;
               if ({7'b0, cur.pend_repeat} > room) begin
                  cnt = room[BYTE_W-1:0];
               end else begin
                  cnt = cur.pend_repeat;
               end
               state_nxt.pend_repeat = '0;
               state_nxt.phase       = PH_CONTROL;
            end
            PH_DONE: begin
               is_data = 1'b0;
            end
         endcase

         if (is_data) begin
            sum                 = {1'b0, cur.out_count} + {8'b0, cnt};
            new_count           = sum[LIMIT_W-1:0];
            state_nxt.out_count = new_count;
            res_hit             = 1'b1;
            res.out_byte        = src_byte;
            res.repeat_count    = cnt;
            res.bytes_consumed  = state_nxt.src_count;
            if (new_count >= output_limit) begin
               res.done_res       = 1'b1;
               state_nxt.phase    = PH_DONE;
               state_nxt.lit_left = '0;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/packbits_run_decoder_core.sv -----
`default_nettype none

// channel | direction | handshake          | payload
// req     | in        | req_tvalid/tready  | tdata src_byte, tuser restart
// rsp     | out       | rsp_tvalid/tready  | tdata out_byte, repeat_count, bytes_consumed;
//         |           |                    | tuser done_res
// csr     | in        | csr_valid/ready    | csr_data output_limit
//
// one request per cycle while the skid is empty; a result is registered before it leaves
// the decode step is one pass of logic from the request to the state and result registers
// a two-entry output (result register plus skid) keeps req_tready from the rsp side
// reset clears decode state, output limit and both output entries
// csr writes are always taken and apply to the next request

module packbits_run_decoder_core
   import pbrd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [7:0] src_byte
   input  wire logic                  req_tuser,   // [0] restart
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [7:0] out_byte, [15:8] repeat_count,
                                                   // [31:16] bytes_consumed
   output logic                       rsp_tuser,   // [0] done_res
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [LIMIT_W-1:0]    csr_data
);

   state_type          state_ff, state_in, state_step;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   result_type         out_ff, out_in, skid_ff, skid_in, res;
   logic               out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic               res_hit, req_fire, rsp_fire, push;

   pbrd_step u_step (
      .state_cur    (state_ff),
      .src_byte     (req_tdata[BYTE_W-1:0]),
      .restart      (req_tuser),
      .output_limit (limit_ff),
      .state_nxt    (state_step),
      .res_hit      (res_hit),
      .res          (res)
   );

   assign csr_ready  = 1'b1;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.bytes_consumed, out_ff.repeat_count, out_ff.out_byte};
   assign rsp_tuser  = out_ff.done_res;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = out_valid_ff && rsp_tready;
   assign push     = req_fire && res_hit;

   always_comb begin
      limit_in      = (csr_valid && csr_ready) ? csr_data : limit_ff;
      state_in      = req_fire ? state_step : state_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_fire) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || rsp_fire) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_fire) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_CLEAR;
         limit_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without a result in the output register");

   a_literal_left: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_LITERAL |-> state_ff.lit_left != '0)
      else $error("literal phase with no literal bytes left");

   a_repeat_len: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_REPEAT |->
         (state_ff.pend_repeat >= 8'd2 && state_ff.pend_repeat <= 8'd129))
      else $error("pending run length out of range");

   a_control_clean: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase == PH_CONTROL |-> state_ff.lit_left == '0)
      else $error("control phase with literal bytes outstanding");

   a_done_zero_count: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.repeat_count == '0) |-> out_ff.done_res)
      else $error("empty result without done");

endmodule

`default_nettype wire
